### rtl/core/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
// Used by every module of the block but the checker; depends on nothing.

package hcbp_pkg;

    localparam int SYMBOLS_DEF      = 256;
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int CODE_W           = 32;
    localparam int LEN_W            = 6;
    localparam int BYTE_W           = 8;
    localparam int MAX_BYTES        = 4;
    localparam int CNT_W            = 3;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2
    } mode_t;

    // One group of packed bytes handed from the packer to the output buffer.
    typedef struct packed {
        logic                               push;
        logic                               last;
        logic [CNT_W-1:0]                   count;
        logic [MAX_BYTES-1:0][BYTE_W-1:0]   bytes;
    } grp_t;

endpackage

### rtl/core/huffman_code_bit_packer_unit.sv
// Top level of the Huffman code bit packer.
// Depends on hcbp_pkg, hcbp_code_table, hcbp_pack and hcbp_out_buf.

// The block takes one item per cycle on the input channel while in_ready is
// high. An item is either a table load, an encode of one byte, or a flush.
// On acceptance the code table entry is read into a register and, for a load,
// the entry is written at the same edge, so an encode may follow a load of
// the same symbol in the very next cycle. In the following cycle the packing
// stage appends the code to the pending bits and forms up to four complete
// bytes, which move as one group into the output buffer; the first byte
// appears on the output in the cycle after that. The output buffer sends one
// byte per cycle while out_ready is high, and the next item that makes bytes
// waits in the packing stage while a group drains: the sustained rate is one
// item per cycle, or one output byte per cycle when items make more than one
// byte each. Loads, flushes that find no leftover bits, and encodes of
// zero-length codes never stall. in_ready falls only while the output buffer
// still holds bytes that have not been taken. There is no clearing pass after
// reset; encoding a symbol that was never loaded gives undefined bytes.

module huffman_code_bit_packer_unit #(
    parameter int SYMBOLS      = hcbp_pkg::SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic [7:0]                   symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]  code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]   code_len,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   out_byte,
    output logic                         last_byte
);

    logic                        accept;
    logic [hcbp_pkg::CODE_W-1:0] rd_bits;
    logic [hcbp_pkg::LEN_W-1:0]  rd_len;
    logic                        sym_ok;
    logic                        grp_free;
    logic                        stage_free;
    hcbp_pkg::grp_t              grp;

    // The packing stage frees up either when empty or when it hands its
    // result on in this cycle, so a new item can follow without a gap.
    assign in_ready = stage_free;
    assign accept   = in_valid && in_ready;

    hcbp_code_table #(
        .SYMBOLS      (SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_len    (code_len),
        .rd_bits     (rd_bits),
        .rd_len      (rd_len),
        .sym_ok      (sym_ok)
    );

    hcbp_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .mode       (mode),
        .sym_ok     (sym_ok),
        .rd_bits    (rd_bits),
        .rd_len     (rd_len),
        .grp_free   (grp_free),
        .stage_free (stage_free),
        .grp        (grp)
    );

    hcbp_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp       (grp),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .last_byte (last_byte),
        .grp_free  (grp_free)
    );

endmodule

### rtl/core/hcbp_code_table.sv
// Code table memory with load checking and the overlong error counter.
// Depends on hcbp_pkg.

module hcbp_code_table #(
    parameter int SYMBOLS      = hcbp_pkg::SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [1:0]                   mode,
    input  logic [7:0]                   symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]  code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]   code_len,
    output logic [hcbp_pkg::CODE_W-1:0]  rd_bits,
    output logic [hcbp_pkg::LEN_W-1:0]   rd_len,
    output logic                         sym_ok
);

    localparam int IDX_W   = $clog2(SYMBOLS);
    localparam int LEN_CAP = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                               : hcbp_pkg::CODE_W;
    localparam int ENTRY_W = hcbp_pkg::CODE_W + hcbp_pkg::LEN_W;

    logic [ENTRY_W-1:0]          table_mem_reg [SYMBOLS];
    logic [ENTRY_W-1:0]          rd_entry_reg;
    logic                        sym_ok_reg;
    logic [15:0]                 err_cnt_reg;
    logic [15:0]                 err_cnt_next;
    logic                        in_range;
    logic                        is_load;
    logic                        too_long;
    logic [hcbp_pkg::CODE_W-1:0] masked_bits;
    logic [IDX_W-1:0]            idx;

    assign in_range = {1'b0, symbol} < 9'(SYMBOLS);
    assign idx      = symbol[IDX_W-1:0];
    assign is_load  = (hcbp_pkg::mode_t'(mode) == hcbp_pkg::MODE_LOAD);
    assign too_long = code_len > hcbp_pkg::LEN_W'(LEN_CAP);

    // Bits above the code length are dropped before they are stored.
    always_comb
    begin
        for (int i = 0; i < hcbp_pkg::CODE_W; i++)
        begin
            masked_bits[i] = code_bits[i] & (hcbp_pkg::LEN_W'(i) < code_len);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_load && in_range && !too_long)
        begin
            table_mem_reg[idx] <= {code_len, masked_bits};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_entry_reg <= table_mem_reg[idx];
            sym_ok_reg   <= in_range;
        end
    end

    // Overlong loads of in-range symbols are counted; the count saturates at the top of the counter.
    always_comb
    begin
        err_cnt_next = err_cnt_reg;
        if (accept && is_load && in_range && too_long && (err_cnt_reg != 16'hFFFF))
        begin
            err_cnt_next = err_cnt_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_cnt_reg <= '0;
        end
        else
        begin
            err_cnt_reg <= err_cnt_next;
        end
    end

    assign rd_bits = rd_entry_reg[hcbp_pkg::CODE_W-1:0];
    assign rd_len  = rd_entry_reg[ENTRY_W-1:hcbp_pkg::CODE_W];
    assign sym_ok  = sym_ok_reg;

endmodule

### rtl/core/hcbp_pack.sv
// Packing stage: merges the looked-up code with the pending bits and forms
// a group of up to four bytes. Depends on hcbp_pkg.

module hcbp_pack (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [1:0]                   mode,
    input  logic                         sym_ok,
    input  logic [hcbp_pkg::CODE_W-1:0]  rd_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]   rd_len,
    input  logic                         grp_free,
    output logic                         stage_free,
    output hcbp_pkg::grp_t               grp
);

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    hcbp_pkg::mode_t             s1_mode_reg;
    logic [6:0]                  pbits_reg;
    logic [6:0]                  pbits_next;
    logic [2:0]                  pcnt_reg;
    logic [2:0]                  pcnt_next;
    logic [5:0]                  total;
    logic [38:0]                 acc;
    logic [39:0]                 aligned;
    logic [7:0]                  flush_byte;
    logic [hcbp_pkg::CNT_W-1:0]  n_bytes;
    logic                        advance;
    logic [hcbp_pkg::MAX_BYTES-1:0][hcbp_pkg::BYTE_W-1:0] grp_bytes;
    logic                        grp_last;

    assign total      = 6'(pcnt_reg) + rd_len;
    assign acc        = (39'(pbits_reg) << rd_len) | 39'(rd_bits);
    assign aligned    = {1'b0, acc} << (6'd40 - total);
    assign flush_byte = {1'b0, pbits_reg} << (4'd8 - {1'b0, pcnt_reg});

    always_comb
    begin
        n_bytes    = '0;
        pbits_next = pbits_reg;
        pcnt_next  = pcnt_reg;
        grp_bytes  = '0;
        grp_last   = 1'b0;
        case (s1_mode_reg)
            hcbp_pkg::MODE_ENCODE:
            begin
                if (sym_ok)
                begin
                    n_bytes   = total[5:3];
                    pcnt_next = total[2:0];
                    pbits_next = acc[6:0] & 7'((8'd1 << total[2:0]) - 8'd1);
                    for (int k = 0; k < hcbp_pkg::MAX_BYTES; k++)
                    begin
                        grp_bytes[k] = aligned[39-8*k -: 8];
                    end
                end
            end
            hcbp_pkg::MODE_FLUSH:
            begin
                if (pcnt_reg != 3'd0)
                begin
                    n_bytes      = hcbp_pkg::CNT_W'(1);
                    grp_bytes[0] = flush_byte;
                    grp_last     = 1'b1;
                    pbits_next   = '0;
                    pcnt_next    = '0;
                end
            end
            default:
            begin
                n_bytes = '0;
            end
        endcase
    end

    assign advance    = s1_valid_reg && ((n_bytes == '0) || grp_free);
    assign stage_free = !s1_valid_reg || advance;
    assign grp.bytes  = grp_bytes;
    assign grp.last   = grp_last;
    assign grp.count  = n_bytes;
    assign grp.push   = advance && (n_bytes != '0);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= hcbp_pkg::mode_t'(mode);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pbits_reg    <= '0;
            pcnt_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                pbits_reg <= pbits_next;
                pcnt_reg  <= pcnt_next;
            end
        end
    end

endmodule

### rtl/core/hcbp_out_buf.sv
// Output buffer: holds one group of packed bytes and hands them out one
// item per cycle while out_ready is high. Depends on hcbp_pkg.

module hcbp_out_buf (
    input  logic           clk,
    input  logic           rst_n,
    input  hcbp_pkg::grp_t grp,
    input  logic           out_ready,
    output logic           out_valid,
    output logic [7:0]     out_byte,
    output logic           last_byte,
    output logic           grp_free
);

    logic [hcbp_pkg::MAX_BYTES-1:0][hcbp_pkg::BYTE_W-1:0] bytes_reg;
    logic                                                 last_reg;
    logic [hcbp_pkg::CNT_W-1:0]                           cnt_reg;
    logic [hcbp_pkg::CNT_W-1:0]                           cnt_next;
    logic [1:0]                                           idx_reg;
    logic [1:0]                                           idx_next;
    logic                                                 take;

    assign out_valid = (cnt_reg != '0);
    assign take      = out_valid && out_ready;
    assign grp_free  = (cnt_reg == '0) || ((cnt_reg == hcbp_pkg::CNT_W'(1)) && out_ready);
    assign out_byte  = bytes_reg[idx_reg];
    assign last_byte = last_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (grp.push)
        begin
            cnt_next = grp.count;
            idx_next = '0;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - hcbp_pkg::CNT_W'(1);
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp.push)
        begin
            bytes_reg <= grp.bytes;
            last_reg  <= grp.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

endmodule

### rtl/core/hcbp_checker.sv
// Port-level checks for the Huffman code bit packer, bound to the top level.
// Depends on huffman_code_bit_packer_unit only through its ports.

module hcbp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_byte
);

    // A byte offered and not taken stays unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte))
    else $error("output item changed while stalled");

    // The input is only held back while bytes wait on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
    else $error("input stalled with nothing waiting on the output");

    // Nothing is offered straight after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
    else $error("output valid right after reset");

    // With the output drained, the block never refuses an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input not ready with an empty output");

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_byte (last_byte)
);
